// ===== hdl/bdc_pkg.sv =====
// bdc_pkg: shared types, constants and register codes of the box clusterer
// used by bdc_pair_test, box_dbscan_clusterer_top and bdc_checker
`timescale 1ns / 1ps
`default_nettype none
package bdc_pkg;

  localparam int unsigned MAX_BOXES_DEF  = 32;
  localparam int unsigned COORD_BITS_DEF = 12;
  localparam int unsigned RESULT_LIMIT   = 32;

  localparam int unsigned FIELD_W  = 12;
  localparam int unsigned RADIUS_W = 24;
  localparam int unsigned MINPTS_W = 6;
  localparam int unsigned WEIGHT_W = 12;
  localparam int unsigned CAP_W    = 12;
  localparam int unsigned IDX_W    = 5;
  localparam int unsigned CFG_IDX_W  = 3;
  localparam int unsigned CFG_DATA_W = 24;

  // register indexes
  typedef logic [CFG_IDX_W-1:0] cfg_idx_t;
  localparam cfg_idx_t CFG_RADIUS  = 3'd0;
  localparam cfg_idx_t CFG_MINPTS  = 3'd1;
  localparam cfg_idx_t CFG_OVL_WT  = 3'd2;
  localparam cfg_idx_t CFG_EDGE_WT = 3'd3;
  localparam cfg_idx_t CFG_CAP     = 3'd4;

  // register reset values
  localparam logic [RADIUS_W-1:0] RADIUS_RST  = 24'd12800;
  localparam logic [MINPTS_W-1:0] MINPTS_RST  = 6'd2;
  localparam logic [WEIGHT_W-1:0] OVL_WT_RST  = 12'd256;
  localparam logic [WEIGHT_W-1:0] EDGE_WT_RST = 12'd256;
  localparam logic [CAP_W-1:0]    CAP_RST     = 12'd100;

  typedef struct packed {
    logic [FIELD_W-1:0] box_left;
    logic [FIELD_W-1:0] box_top;
    logic [FIELD_W-1:0] box_width;
    logic [FIELD_W-1:0] box_height;
    logic               frame_end;
  } box_in_t;

  typedef struct packed {
    logic [IDX_W-1:0] member_index;
    logic [IDX_W-1:0] cluster_number;
    logic             cluster_end;
    logic             frame_done;
    logic             no_clusters;
    logic             boxes_dropped;
  } result_t;

  typedef struct packed {
    logic [RADIUS_W-1:0] neighbor_radius;
    logic [MINPTS_W-1:0] min_points;
    logic [WEIGHT_W-1:0] overlap_weight;
    logic [WEIGHT_W-1:0] edge_weight;
    logic [CAP_W-1:0]    distance_cap;
  } cfg_t;

  // tag that travels with a pair through the neighbour test
  typedef struct packed {
    logic pair;
    logic last;
  } pt_tag_t;

endpackage
`default_nettype wire

// ===== hdl/bdc_pair_test.sv =====
// bdc_pair_test: five-stage pipelined neighbour test of two boxes
// depends on bdc_pkg (cfg_t, pt_tag_t, widths)
`timescale 1ns / 1ps
`default_nettype none
module bdc_pair_test #(
  parameter int unsigned COORD_BITS = bdc_pkg::COORD_BITS_DEF
) (
  input  wire logic                    clk_i,
  input  wire logic                    rst_ni,
  input  wire bdc_pkg::cfg_t           cfg_i,
  input  wire logic [4*COORD_BITS-1:0] box_a_i,
  input  wire logic [4*COORD_BITS-1:0] box_b_i,
  input  wire logic                    valid_i,
  input  wire bdc_pkg::pt_tag_t        tag_i,
  output logic                         valid_o,
  output bdc_pkg::pt_tag_t             tag_o,
  output logic                         nb_o
);
  import bdc_pkg::*;

  localparam int unsigned CB = COORD_BITS;
  localparam int unsigned RW = CB + 1;
  localparam int unsigned GW = (RW > CAP_W) ? RW : CAP_W;
  localparam int unsigned AW = 2 * CB + 2;
  localparam int unsigned OW = WEIGHT_W + CAP_W;
  localparam int unsigned PW = OW + AW;
  localparam int unsigned SW = PW + 1;
  localparam int unsigned NST = 5;

  logic [CB-1:0] la, ta, wa, ha, lb, tb, wb, hb;
  logic [RW-1:0] ra, ba, rb, bb, gx, gy, g, ix0, ix1, iy0, iy1;
  logic          xg1, xg2, yg1, yg2, x_dis, y_dis;
  logic [GW-1:0] gg, capg, edge_full;

  // stage A: gaps, edge term and intersection extents
  always_comb begin
    la = box_a_i[4*CB-1 -: CB];
    ta = box_a_i[3*CB-1 -: CB];
    wa = box_a_i[2*CB-1 -: CB];
    ha = box_a_i[CB-1 -: CB];
    lb = box_b_i[4*CB-1 -: CB];
    tb = box_b_i[3*CB-1 -: CB];
    wb = box_b_i[2*CB-1 -: CB];
    hb = box_b_i[CB-1 -: CB];
    ra = RW'(la) + RW'(wa);
    ba = RW'(ta) + RW'(ha);
    rb = RW'(lb) + RW'(wb);
    bb = RW'(tb) + RW'(hb);
    xg1 = ra < RW'(lb);
    xg2 = rb < RW'(la);
    yg1 = ba < RW'(tb);
    yg2 = bb < RW'(ta);
    x_dis = xg1 | xg2;
    y_dis = yg1 | yg2;
    gx = xg1 ? (RW'(lb) - ra) : (RW'(la) - rb);
    gy = yg1 ? (RW'(tb) - ba) : (RW'(ta) - bb);
    if (x_dis && y_dis) begin
      g = (gx < gy) ? gx : gy;
    end else if (x_dis) begin
      g = gx;
    end else begin
      g = gy;
    end
    gg   = GW'(g);
    capg = GW'(cfg_i.distance_cap);
    if (x_dis || y_dis) begin
      edge_full = (gg < capg) ? gg : capg;
    end else begin
      edge_full = '0;
    end
    ix0 = (la > lb) ? RW'(la) : RW'(lb);
    ix1 = (ra < rb) ? ra : rb;
    iy0 = (ta > tb) ? RW'(ta) : RW'(tb);
    iy1 = (ba < bb) ? ba : bb;
  end

  logic [CAP_W-1:0] edge_q;
  logic [RW-1:0]    dx_q, dy_q;
  logic             ipos_q;
  logic [CB-1:0]    wa_q, ha_q, wb_q, hb_q;

  logic [AW-1:0] inter_q, a1_q, a2_q;
  logic [OW-1:0] owc2_q, ewe2_q;

  logic [AW-1:0] mn, mn_e_q, df_q;
  logic          deg;
  logic [OW-1:0] owc3_q, ewe3_q;

  logic [PW-1:0] t1_q, t2_q, r_q;
  logic          nb_q;

  // stage C helpers: smaller area, degenerate cases fall back to a unit area
  always_comb begin
    mn  = (a1_q < a2_q) ? a1_q : a2_q;
    deg = (inter_q == '0) || (mn == '0);
  end

  // datapath registers
  always_ff @(posedge clk_i) begin
    // stage A
    edge_q <= CAP_W'(edge_full);
    dx_q   <= ix1 - ix0;
    dy_q   <= iy1 - iy0;
    ipos_q <= (ix1 > ix0) && (iy1 > iy0);
    wa_q   <= wa;
    ha_q   <= ha;
    wb_q   <= wb;
    hb_q   <= hb;
    // stage B: products of extents and weights
    inter_q <= ipos_q ? (AW'(dx_q) * AW'(dy_q)) : '0;
    a1_q    <= AW'(wa_q) * AW'(ha_q);
    a2_q    <= AW'(wb_q) * AW'(hb_q);
    owc2_q  <= OW'(cfg_i.overlap_weight) * OW'(cfg_i.distance_cap);
    ewe2_q  <= OW'(cfg_i.edge_weight) * OW'(edge_q);
    // stage C
    mn_e_q <= deg ? AW'(1) : mn;
    df_q   <= deg ? AW'(1) : (mn - inter_q);
    owc3_q <= owc2_q;
    ewe3_q <= ewe2_q;
    // stage D: both sides scaled by the smaller area
    t1_q <= PW'(owc3_q) * PW'(df_q);
    t2_q <= PW'(ewe3_q) * PW'(mn_e_q);
    r_q  <= PW'(cfg_i.neighbor_radius) * PW'(mn_e_q);
    // stage E
    nb_q <= (SW'(t1_q) + SW'(t2_q)) <= SW'(r_q);
  end

  logic    [NST-1:0] vld_q;
  pt_tag_t [NST-1:0] tag_q;

  // valid and tag pipeline
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
      tag_q <= '0;
    end else begin
      vld_q <= {vld_q[NST-2:0], valid_i};
      tag_q <= {tag_q[NST-2:0], tag_i};
    end
  end

  assign valid_o = vld_q[NST-1];
  assign tag_o   = tag_q[NST-1];
  assign nb_o    = nb_q;

endmodule
`default_nettype wire

// ===== hdl/box_dbscan_clusterer_top.sv =====
// box_dbscan_clusterer_top: loads one frame of boxes and emits its DBSCAN clusters
// Loading: one box per cycle. Clustering after the frame_end beat: every region
// query streams all stored boxes through bdc_pair_test, and each core box then
// scans all stored boxes to append its unlisted neighbours to the seed list.
// Emission: each result beat is loaded, then held until it is taken. Reset clears
// control, counts and flags and loads the register defaults; the box and seed
// memories are not cleared. depends on bdc_pkg and bdc_pair_test
`timescale 1ns / 1ps
`default_nettype none
module box_dbscan_clusterer_top #(
  parameter int unsigned MAX_BOXES  = bdc_pkg::MAX_BOXES_DEF,
  parameter int unsigned COORD_BITS = bdc_pkg::COORD_BITS_DEF
) (
  input  wire logic                           clk_i,
  input  wire logic                           rst_ni,
  input  wire logic                           in_valid_i,
  output logic                                in_ready_o,
  input  wire bdc_pkg::box_in_t               in_data_i,
  output logic                                out_valid_o,
  input  wire logic                           out_ready_i,
  output bdc_pkg::result_t                    out_data_o,
  input  wire logic                           cfg_valid_i,
  output logic                                cfg_ready_o,
  input  wire logic [bdc_pkg::CFG_IDX_W-1:0]  cfg_index_i,
  input  wire logic [bdc_pkg::CFG_DATA_W-1:0] cfg_data_i
);
  import bdc_pkg::*;

  localparam int unsigned CB   = COORD_BITS;
  localparam int unsigned BW   = 4 * CB;
  localparam int unsigned IW   = $clog2(MAX_BOXES);
  localparam int unsigned NW   = $clog2(MAX_BOXES + 1);
  localparam int unsigned RL   = RESULT_LIMIT;
  localparam int unsigned EW   = $clog2(RL);
  localparam int unsigned CMPW = ((NW > EW) ? NW : EW) + 2;

  typedef enum logic [3:0] {
    S_LOAD, S_NEXT_I, S_SCAN_RD, S_SCAN_LATCH, S_SCAN_ISSUE, S_SCAN_WAIT,
    S_DECIDE, S_APPEND, S_SEED_NEXT, S_SEED_GET, S_EMIT_START, S_EMIT_LOAD,
    S_EMIT_HOLD
  } state_e;

  state_e state_q;

  // configuration registers
  cfg_t cfg_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.neighbor_radius <= RADIUS_RST;
      cfg_q.min_points      <= MINPTS_RST;
      cfg_q.overlap_weight  <= OVL_WT_RST;
      cfg_q.edge_weight     <= EDGE_WT_RST;
      cfg_q.distance_cap    <= CAP_RST;
    end else if (cfg_valid_i) begin
      case (cfg_index_i)
        CFG_RADIUS:  cfg_q.neighbor_radius <= cfg_data_i[RADIUS_W-1:0];
        CFG_MINPTS:  cfg_q.min_points      <= cfg_data_i[MINPTS_W-1:0];
        CFG_OVL_WT:  cfg_q.overlap_weight  <= cfg_data_i[WEIGHT_W-1:0];
        CFG_EDGE_WT: cfg_q.edge_weight     <= cfg_data_i[WEIGHT_W-1:0];
        CFG_CAP:     cfg_q.distance_cap    <= cfg_data_i[CAP_W-1:0];
        default: ;
      endcase
    end
  end

  assign cfg_ready_o = 1'b1;

  // control and frame state
  logic [NW-1:0]        cnt_q, i_q, m_q, len_q, j_q, total_q;
  logic [IW-1:0]        k_q, kr_q, a_q, p_q;
  logic                 ovf_q, core_q;
  logic [MAX_BOXES-1:0] vis_q, noise_q, nbmask_q, flags_q;
  logic [4:0]           cid_q;
  logic [EW-1:0]        e_q, e_last_q;
  logic [RL-1:0]        endf_q;
  logic [BW-1:0]        pbox_q;
  logic                 iss_vld_q;
  pt_tag_t              iss_tag_q;
  result_t              out_q;
  logic                 out_vld_q;

  // memories
  logic [BW-1:0] box_mem [MAX_BOXES];
  logic [BW-1:0] box_rd_q;
  logic [IW-1:0] seed_mem [MAX_BOXES];
  logic [IW-1:0] seed_rd_q;
  logic [4:0]    res_idx [RL];
  logic [4:0]    res_cid [RL];

  logic          in_acc, box_we, seed_we, rec_en, rec_ok, end_en, m_ok, cnt_full;
  logic [IW-1:0] box_raddr, q_idx, rec_idx;
  logic          q_noise, q_unv;
  logic [BW-1:0] in_box;

  logic    pt_vld, pt_nb;
  pt_tag_t pt_tag;

  always_comb begin
    in_acc    = in_valid_i && (state_q == S_LOAD);
    cnt_full  = (cnt_q == NW'(MAX_BOXES));
    box_we    = in_acc && !cnt_full;
    in_box    = {CB'(in_data_i.box_left), CB'(in_data_i.box_top),
                 CB'(in_data_i.box_width), CB'(in_data_i.box_height)};
    box_raddr = (state_q == S_SCAN_RD) ? p_q : k_q;
    q_idx     = seed_rd_q;
    q_noise   = noise_q[q_idx];
    q_unv     = !noise_q[q_idx] && !vis_q[q_idx];
    m_ok      = CMPW'(m_q) >= CMPW'(cfg_q.min_points);
    seed_we   = (state_q == S_APPEND) && nbmask_q[a_q] && !flags_q[a_q]
                && (len_q < NW'(MAX_BOXES));
    rec_en    = ((state_q == S_DECIDE) && core_q && m_ok)
                || ((state_q == S_SEED_GET) && (q_noise || q_unv));
    rec_idx   = (state_q == S_DECIDE) ? IW'(i_q) : q_idx;
    rec_ok    = CMPW'(total_q) < CMPW'(RL);
    end_en    = (state_q == S_SEED_NEXT) && (j_q == len_q)
                && (CMPW'(total_q) <= CMPW'(RL));
  end

  // box store: one write port for loading, one read port for queries
  always_ff @(posedge clk_i) begin
    if (box_we) begin
      box_mem[IW'(cnt_q)] <= in_box;
    end
    box_rd_q <= box_mem[box_raddr];
  end

  // seed list: appended at len, read at j
  always_ff @(posedge clk_i) begin
    if (seed_we) begin
      seed_mem[IW'(len_q)] <= a_q;
    end
    seed_rd_q <= seed_mem[IW'(j_q)];
  end

  // result list in discovery order
  always_ff @(posedge clk_i) begin
    if (rec_en && rec_ok) begin
      res_idx[EW'(total_q)] <= 5'(rec_idx);
      res_cid[EW'(total_q)] <= cid_q;
    end
  end

  bdc_pair_test #(
    .COORD_BITS(COORD_BITS)
  ) u_pair_test (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .cfg_i   (cfg_q),
    .box_a_i (pbox_q),
    .box_b_i (box_rd_q),
    .valid_i (iss_vld_q),
    .tag_i   (iss_tag_q),
    .valid_o (pt_vld),
    .tag_o   (pt_tag),
    .nb_o    (pt_nb)
  );

  // main sequencer
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= S_LOAD;
      cnt_q     <= '0;
      i_q       <= '0;
      m_q       <= '0;
      len_q     <= '0;
      j_q       <= '0;
      total_q   <= '0;
      k_q       <= '0;
      kr_q      <= '0;
      a_q       <= '0;
      p_q       <= '0;
      ovf_q     <= 1'b0;
      core_q    <= 1'b0;
      vis_q     <= '0;
      noise_q   <= '0;
      nbmask_q  <= '0;
      flags_q   <= '0;
      cid_q     <= '0;
      e_q       <= '0;
      e_last_q  <= '0;
      endf_q    <= '0;
      pbox_q    <= '0;
      iss_vld_q <= 1'b0;
      iss_tag_q <= '0;
      out_q     <= '0;
      out_vld_q <= 1'b0;
    end else begin
      iss_vld_q <= 1'b0;
      iss_tag_q <= '0;
      // gather neighbour verdicts in box order
      if (pt_vld) begin
        if (pt_tag.pair && pt_nb) begin
          nbmask_q[kr_q] <= 1'b1;
          m_q            <= m_q + 1'b1;
        end
        kr_q <= kr_q + 1'b1;
      end
      if (rec_en) begin
        total_q <= total_q + 1'b1;
      end
      if (end_en) begin
        endf_q[EW'(total_q - 1'b1)] <= 1'b1;
      end
      unique case (state_q)
        S_LOAD: begin
          if (in_acc) begin
            if (cnt_full) begin
              ovf_q <= 1'b1;
            end else begin
              cnt_q <= cnt_q + 1'b1;
            end
            if (in_data_i.frame_end) begin
              vis_q   <= '0;
              noise_q <= '0;
              endf_q  <= '0;
              total_q <= '0;
              cid_q   <= '0;
              i_q     <= '0;
              state_q <= S_NEXT_I;
            end
          end
        end
        S_NEXT_I: begin
          if (i_q == cnt_q) begin
            state_q <= S_EMIT_START;
          end else if (vis_q[IW'(i_q)] || noise_q[IW'(i_q)]) begin
            i_q <= i_q + 1'b1;
          end else begin
            p_q     <= IW'(i_q);
            core_q  <= 1'b1;
            state_q <= S_SCAN_RD;
          end
        end
        S_SCAN_RD: begin
          state_q <= S_SCAN_LATCH;
        end
        S_SCAN_LATCH: begin
          pbox_q   <= box_rd_q;
          k_q      <= '0;
          kr_q     <= '0;
          nbmask_q <= '0;
          m_q      <= '0;
          state_q  <= S_SCAN_ISSUE;
        end
        S_SCAN_ISSUE: begin
          iss_vld_q      <= 1'b1;
          iss_tag_q.pair <= (k_q != p_q);
          iss_tag_q.last <= (k_q == IW'(cnt_q - 1'b1));
          k_q            <= k_q + 1'b1;
          if (k_q == IW'(cnt_q - 1'b1)) begin
            state_q <= S_SCAN_WAIT;
          end
        end
        S_SCAN_WAIT: begin
          if (pt_vld && pt_tag.last) begin
            state_q <= S_DECIDE;
          end
        end
        S_DECIDE: begin
          a_q <= '0;
          if (core_q) begin
            if (!m_ok) begin
              noise_q[IW'(i_q)] <= 1'b1;
              i_q               <= i_q + 1'b1;
              state_q           <= S_NEXT_I;
            end else begin
              vis_q[IW'(i_q)] <= 1'b1;
              flags_q         <= '0;
              len_q           <= '0;
              j_q             <= '0;
              state_q         <= S_APPEND;
            end
          end else begin
            state_q <= m_ok ? S_APPEND : S_SEED_NEXT;
          end
        end
        S_APPEND: begin
          if (seed_we) begin
            flags_q[a_q] <= 1'b1;
            len_q        <= len_q + 1'b1;
          end
          a_q <= a_q + 1'b1;
          if (a_q == IW'(cnt_q - 1'b1)) begin
            state_q <= S_SEED_NEXT;
          end
        end
        S_SEED_NEXT: begin
          if (j_q == len_q) begin
            cid_q   <= cid_q + 1'b1;
            i_q     <= i_q + 1'b1;
            state_q <= S_NEXT_I;
          end else begin
            state_q <= S_SEED_GET;
          end
        end
        S_SEED_GET: begin
          j_q <= j_q + 1'b1;
          if (q_noise) begin
            noise_q[q_idx] <= 1'b0;
            vis_q[q_idx]   <= 1'b1;
            state_q        <= S_SEED_NEXT;
          end else if (q_unv) begin
            vis_q[q_idx] <= 1'b1;
            p_q          <= q_idx;
            core_q       <= 1'b0;
            state_q      <= S_SCAN_RD;
          end else begin
            state_q <= S_SEED_NEXT;
          end
        end
        S_EMIT_START: begin
          e_q <= '0;
          if (total_q == '0) begin
            out_q               <= '0;
            out_q.frame_done    <= 1'b1;
            out_q.no_clusters   <= 1'b1;
            out_q.boxes_dropped <= ovf_q;
            out_vld_q           <= 1'b1;
            state_q             <= S_EMIT_HOLD;
          end else begin
            e_last_q <= rec_ok ? EW'(total_q - 1'b1) : EW'(RL - 1);
            state_q  <= S_EMIT_LOAD;
          end
        end
        S_EMIT_LOAD: begin
          out_q.member_index   <= res_idx[e_q];
          out_q.cluster_number <= res_cid[e_q];
          out_q.cluster_end    <= endf_q[e_q];
          out_q.frame_done     <= (e_q == e_last_q);
          out_q.no_clusters    <= 1'b0;
          out_q.boxes_dropped  <= ovf_q;
          out_vld_q            <= 1'b1;
          state_q              <= S_EMIT_HOLD;
        end
        S_EMIT_HOLD: begin
          if (out_ready_i) begin
            out_vld_q <= 1'b0;
            if (out_q.frame_done) begin
              cnt_q   <= '0;
              ovf_q   <= 1'b0;
              state_q <= S_LOAD;
            end else begin
              e_q     <= e_q + 1'b1;
              state_q <= S_EMIT_LOAD;
            end
          end
        end
        default: state_q <= S_LOAD;
      endcase
    end
  end

  assign in_ready_o  = (state_q == S_LOAD);
  assign out_valid_o = out_vld_q;
  assign out_data_o  = out_q;

endmodule
`default_nettype wire

// ===== hdl/bdc_checker.sv =====
// bdc_checker: port-level checks of the box clusterer, bound to the top level
// depends on bdc_pkg and box_dbscan_clusterer_top
`timescale 1ns / 1ps
`default_nettype none
module bdc_checker (
  input wire logic             clk_i,
  input wire logic             rst_ni,
  input wire logic             in_ready_o,
  input wire logic             out_valid_o,
  input wire logic             out_ready_i,
  input wire bdc_pkg::result_t out_data_o
);
  import bdc_pkg::*;

  // a stalled result beat holds
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(out_data_o))
    else $error("result beat changed while stalled");

  // empty-frame beat is the only and last beat, with index, cluster number and cluster_end zero
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_data_o.no_clusters |-> out_data_o.frame_done
      && out_data_o.member_index == '0 && out_data_o.cluster_number == '0
      && !out_data_o.cluster_end)
    else $error("malformed empty-frame beat");

  // no box is taken while results are pending
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> !in_ready_o)
    else $error("input ready during emission");

  // after the last beat of a frame the block is ready for the next frame
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_ready_i && out_data_o.frame_done |=> in_ready_o)
    else $error("not ready after frame end");

endmodule

bind box_dbscan_clusterer_top bdc_checker u_bdc_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_ready_o  (in_ready_o),
  .out_valid_o (out_valid_o),
  .out_ready_i (out_ready_i),
  .out_data_o  (out_data_o)
);
`default_nettype wire
